### sv/soft_knee_compressor_macros.svh
// assertion macros for the soft knee compressor
`ifndef SOFT_KNEE_COMPRESSOR_MACROS_SVH
`define SOFT_KNEE_COMPRESSOR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication on clk_i, off during reset
`define SKC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("soft knee compressor check failed");
// next-cycle implication on clk_i, off during reset
`define SKC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("soft knee compressor check failed");
`else
`define SKC_ASSERT_IMP(label, ante, cons)
`define SKC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### sv/skc_pkg.sv
// shared types, constants and tables of the soft knee compressor
`timescale 1ns / 1ps
package skc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int POS_W       = $clog2(SAMPLE_BITS);
  localparam int NEGL_W      = POS_W + 16;
  localparam int LEVEL_W     = 18;
  localparam int GAIN_W      = 17;
  localparam int E_W         = 17;
  localparam int NUM_W       = 37;
  localparam int DIV_W       = 26;
  localparam int X_W         = 22;
  localparam int MANT_W      = 32;
  localparam int MULT_W      = 31;
  localparam int TAB_W       = 30;
  localparam int CNT_W       = 6;
  localparam int ADDR_W      = 4;
  localparam int LOG_STEPS   = 16;
  localparam int EXP_STEPS   = 16;
  localparam int DIV_STEPS   = NUM_W;

  localparam logic [GAIN_W-1:0]         UNITY_GAIN  = GAIN_W'(65536);
  localparam logic signed [LEVEL_W-1:0] FLOOR_LEVEL = LEVEL_W'(-40960);
  localparam logic [26:0]               DB_PER_LOG2 = 27'd101008905;
  localparam logic [21:0]               LOG2_PER_DB = 22'd2786635;
  localparam logic [12:0]               RATIO_MIN   = 13'd256;

  typedef enum logic [1:0] {
    REG_THRESHOLD,
    REG_RATIO,
    REG_ATTACK,
    REG_RELEASE
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOG,
    ST_LEVEL,
    ST_KNEE1,
    ST_KNEE2,
    ST_DIV_INIT,
    ST_DIV,
    ST_GAIN_X,
    ST_EXP,
    ST_SHIFT,
    ST_SMOOTH,
    ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_LOG,
    OP_LEVEL,
    OP_KNEE1,
    OP_KNEE2,
    OP_DIV_INIT,
    OP_DIV,
    OP_GAIN_X,
    OP_EXP,
    OP_SHIFT,
    OP_SMOOTH,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [CNT_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] threshold_db;
    logic [12:0]        ratio;
    logic [15:0]        attack_coeff;
    logic [15:0]        release_coeff;
  } cfg_t;

  typedef logic [EXP_STEPS-1:0][TAB_W-1:0] exp_tab_t;

  // floor square root of a 60-bit value
  function automatic logic [TAB_W-1:0] isqrt60(logic [59:0] v);
    logic [59:0] rem;
    logic [59:0] res;
    logic [59:0] b;
    rem = v;
    res = '0;
    b   = 60'd1 << 58;
    for (int i = 0; i < 30; i++) begin
      if (rem >= res + b) begin
        rem = rem - res - b;
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[TAB_W-1:0];
  endfunction

  // 2^-(2^-k) factors in Q30 for k = 0..15
  function automatic exp_tab_t exp_table();
    logic [TAB_W-1:0] c;
    exp_tab_t         t;
    c = TAB_W'(1) << 29;
    t = '0;
    for (int k = 0; k < EXP_STEPS; k++) begin
      if (k > 0) begin
        c = isqrt60({c, 30'd0});
      end
      t[k] = c;
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = exp_table();

endpackage

### sv/soft_knee_compressor.sv
// soft knee compressor top level: one sample at a time, no new sample is taken until
// its result is written to the output register; the sequence runs the 16-step log
// squaring loop, the 37-step restoring divider and the 16-step exp product loop
// a finished result waits in the output register while the next sample is taken
// rst_ni is asynchronous, active low: unity gain, register defaults, no result pending
`timescale 1ns / 1ps
`include "soft_knee_compressor_macros.svh"
module soft_knee_compressor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [skc_pkg::ADDR_W-1:0]      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // sample in
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [skc_pkg::SAMPLE_BITS-1:0] sample_in_i,
  // result out
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [skc_pkg::SAMPLE_BITS-1:0] sample_out_o,
  output logic [skc_pkg::GAIN_W-1:0]      gain_now_o
);

  skc_pkg::cfg_t cfg;
  skc_pkg::cmd_t cmd;

  // threshold, ratio and smoothing coefficients
  skc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: one sample at a time through log, curve, divide, exp and smoothing
  skc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // datapath holds the smoothed gain state and the output register
  skc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_i        (cfg),
    .sample_i     (sample_in_i),
    .sample_out_o (sample_out_o),
    .gain_now_o   (gain_now_o)
  );

  // gain never exceeds unity
  `SKC_ASSERT_IMP(a_gain_range, out_valid_o, gain_now_o <= 17'd65536)
  // a new sample is only taken while the sequencer is idle
  `SKC_ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o)
  // a result never appears right after a sample is taken
  `SKC_ASSERT_NEXT(a_no_early_result, in_valid_i && in_ready_o, !(out_valid_o && !$past(out_valid_o)))

endmodule

### sv/skc_regs.sv
// configuration register file on the apb-style port
`timescale 1ns / 1ps
module skc_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [skc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output skc_pkg::cfg_t             cfg_o
);

  skc_pkg::cfg_t     cfg_q;
  skc_pkg::reg_idx_e idx;
  logic              wr;

  assign idx    = skc_pkg::reg_idx_e'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold_db  <= -16'sd5120;
      cfg_q.ratio         <= 13'd1024;
      cfg_q.attack_coeff  <= 16'd273;
      cfg_q.release_coeff <= 16'd14;
    end else if (wr) begin
      unique case (idx)
        skc_pkg::REG_THRESHOLD: cfg_q.threshold_db  <= pwdata[15:0];
        skc_pkg::REG_RATIO:     cfg_q.ratio         <= pwdata[12:0];
        skc_pkg::REG_ATTACK:    cfg_q.attack_coeff  <= pwdata[15:0];
        skc_pkg::REG_RELEASE:   cfg_q.release_coeff <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      skc_pkg::REG_THRESHOLD: prdata = {16'd0, cfg_q.threshold_db};
      skc_pkg::REG_RATIO:     prdata = {19'd0, cfg_q.ratio};
      skc_pkg::REG_ATTACK:    prdata = {16'd0, cfg_q.attack_coeff};
      skc_pkg::REG_RELEASE:   prdata = {16'd0, cfg_q.release_coeff};
    endcase
  end

endmodule

### sv/skc_ctrl.sv
// sequencer of the compressor datapath and output handshake
`timescale 1ns / 1ps
module skc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output skc_pkg::cmd_t cmd_o
);

  skc_pkg::state_e                state_q, state_d;
  logic [skc_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic                           out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= skc_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmd_o.op     = skc_pkg::OP_NONE;
    cmd_o.step   = cnt_q;
    in_ready_o   = (state_q == skc_pkg::ST_IDLE);
    unique case (state_q)
      skc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = skc_pkg::OP_LOAD;
          cnt_d    = '0;
          state_d  = skc_pkg::ST_LOG;
        end
      end
      skc_pkg::ST_LOG: begin
        cmd_o.op = skc_pkg::OP_LOG;
        if (cnt_q == skc_pkg::CNT_W'(skc_pkg::LOG_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = skc_pkg::ST_LEVEL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      skc_pkg::ST_LEVEL: begin
        cmd_o.op = skc_pkg::OP_LEVEL;
        state_d  = skc_pkg::ST_KNEE1;
      end
      skc_pkg::ST_KNEE1: begin
        cmd_o.op = skc_pkg::OP_KNEE1;
        state_d  = skc_pkg::ST_KNEE2;
      end
      skc_pkg::ST_KNEE2: begin
        cmd_o.op = skc_pkg::OP_KNEE2;
        state_d  = skc_pkg::ST_DIV_INIT;
      end
      skc_pkg::ST_DIV_INIT: begin
        cmd_o.op = skc_pkg::OP_DIV_INIT;
        cnt_d    = '0;
        state_d  = skc_pkg::ST_DIV;
      end
      skc_pkg::ST_DIV: begin
        cmd_o.op = skc_pkg::OP_DIV;
        if (cnt_q == skc_pkg::CNT_W'(skc_pkg::DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = skc_pkg::ST_GAIN_X;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      skc_pkg::ST_GAIN_X: begin
        cmd_o.op = skc_pkg::OP_GAIN_X;
        cnt_d    = '0;
        state_d  = skc_pkg::ST_EXP;
      end
      skc_pkg::ST_EXP: begin
        cmd_o.op = skc_pkg::OP_EXP;
        if (cnt_q == skc_pkg::CNT_W'(skc_pkg::EXP_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = skc_pkg::ST_SHIFT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      skc_pkg::ST_SHIFT: begin
        cmd_o.op = skc_pkg::OP_SHIFT;
        state_d  = skc_pkg::ST_SMOOTH;
      end
      skc_pkg::ST_SMOOTH: begin
        cmd_o.op = skc_pkg::OP_SMOOTH;
        state_d  = skc_pkg::ST_OUT;
      end
      skc_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = skc_pkg::OP_OUT;
          state_d  = skc_pkg::ST_IDLE;
        end
      end
      default: state_d = skc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.op == skc_pkg::OP_OUT) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### sv/skc_dp.sv
// compressor datapath: log, curve, divider, exp, smoother, output scaling
`timescale 1ns / 1ps
module skc_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  skc_pkg::cmd_t                    cmd_i,
  input  skc_pkg::cfg_t                    cfg_i,
  input  logic [skc_pkg::SAMPLE_BITS-1:0]  sample_i,
  output logic [skc_pkg::SAMPLE_BITS-1:0]  sample_out_o,
  output logic [skc_pkg::GAIN_W-1:0]       gain_now_o
);

  localparam int SB = skc_pkg::SAMPLE_BITS;
  localparam int LP_W = skc_pkg::NEGL_W + 27;
  localparam int XP_W = skc_pkg::E_W + 22;
  localparam int MP_W = SB + skc_pkg::GAIN_W + 1;

  // registers
  logic                              neg_q, zero_q, hi_q, mid_q;
  logic [SB-1:0]                     m_q;
  logic [skc_pkg::POS_W-1:0]         pos_q;
  logic [skc_pkg::MANT_W-1:0]        y_q;
  logic [15:0]                       frac_q;
  logic signed [skc_pkg::LEVEL_W-1:0] level_q;
  logic [skc_pkg::E_W-1:0]           over_q;
  logic [23:0]                       dd_q;
  logic [12:0]                       r_q;
  logic [skc_pkg::NUM_W-1:0]         knum_q, quo_q;
  logic [skc_pkg::DIV_W-1:0]         rem_q, div_q;
  logic [skc_pkg::X_W-1:0]           x_q;
  logic [skc_pkg::MULT_W-1:0]        mult_q;
  logic [skc_pkg::GAIN_W-1:0]        target_q, gain_q, gain_d, gain_out_q;
  logic [SB-1:0]                     sample_out_q;

  // combinational
  logic [SB-1:0]                     mag_in;
  logic [skc_pkg::POS_W-1:0]         lead;
  logic [5:0]                        lshift;
  logic [63:0]                       sq;
  logic [skc_pkg::MANT_W-1:0]        sq_sh;
  logic [skc_pkg::NEGL_W-1:0]        negl;
  logic [LP_W-1:0]                   lp;
  logic [skc_pkg::LEVEL_W-1:0]       lvl_mag;
  logic signed [18:0]                thr_x, level_x, diff;
  logic [18:0]                       dpos;
  logic [12:0]                       r_eff;
  logic [skc_pkg::DIV_W:0]           rem_s;
  logic                              ge;
  logic [skc_pkg::E_W-1:0]           e_val;
  logic [XP_W-1:0]                   xp;
  logic [3:0]                        k;
  logic [60:0]                       ep;
  logic [5:0]                        ip, sh;
  logic [45:0]                       rsum;
  logic                              fall;
  logic [skc_pkg::GAIN_W-1:0]        gdiff, gstep;
  logic [15:0]                       coeff;
  logic [32:0]                       sp;
  logic [MP_W-1:0]                   mp;
  logic [SB-1:0]                     mag_out;

  assign mag_in = sample_i[SB-1] ? (~sample_i + SB'(1)) : sample_i;

  always_comb begin
    lead = '0;
    for (int i = 0; i < SB; i++) begin
      if (mag_in[i]) lead = skc_pkg::POS_W'(i);
    end
  end
  assign lshift = 6'd30 - 6'(lead);

  // log2 by repeated squaring
  assign sq    = 64'(y_q) * 64'(y_q);
  assign sq_sh = sq[61:30];

  assign negl = ((skc_pkg::NEGL_W'(SB - 1) - skc_pkg::NEGL_W'(pos_q)) << 16)
              - skc_pkg::NEGL_W'(frac_q);
  assign lp      = LP_W'(negl) * LP_W'(skc_pkg::DB_PER_LOG2) + (LP_W'(1) << 31);
  assign lvl_mag = skc_pkg::LEVEL_W'(lp >> 32);

  // curve
  assign thr_x   = 19'(cfg_i.threshold_db);
  assign level_x = 19'(level_q);
  assign diff    = level_x - thr_x;
  assign dpos    = 19'(diff + 19'sd1536);
  assign r_eff   = (cfg_i.ratio < skc_pkg::RATIO_MIN) ? skc_pkg::RATIO_MIN : cfg_i.ratio;

  // restoring divider step
  assign rem_s = {rem_q, quo_q[skc_pkg::NUM_W-1]};
  assign ge    = rem_s >= {1'b0, div_q};

  // attenuation and its log2
  always_comb begin
    if (hi_q) begin
      e_val = over_q - skc_pkg::E_W'(quo_q);
    end else if (mid_q) begin
      e_val = skc_pkg::E_W'(quo_q);
    end else begin
      e_val = '0;
    end
  end
  assign xp = XP_W'(e_val) * XP_W'(skc_pkg::LOG2_PER_DB) + XP_W'(32768);

  // exp by factor products
  assign k  = cmd_i.step[3:0];
  assign ep = 61'(mult_q) * 61'(skc_pkg::EXP_TAB[k]) + (61'(1) << 29);
  assign ip = x_q[skc_pkg::X_W-1:16];
  assign sh = ip + 6'd14;
  assign rsum = 46'(mult_q) + (46'(1) << (sh - 6'd1));

  // smoother
  assign fall  = target_q < gain_q;
  assign gdiff = fall ? (gain_q - target_q) : (target_q - gain_q);
  assign coeff = fall ? cfg_i.attack_coeff : cfg_i.release_coeff;
  assign sp    = 33'(gdiff) * 33'(coeff) + 33'd32768;
  assign gstep = skc_pkg::GAIN_W'(sp >> 16);

  always_comb begin
    gain_d = gain_q;
    if (cmd_i.op == skc_pkg::OP_SMOOTH) begin
      gain_d = fall ? (gain_q - gstep) : (gain_q + gstep);
    end
  end

  // output scaling
  assign mp      = MP_W'(m_q) * MP_W'(gain_q) + MP_W'(32768);
  assign mag_out = SB'(mp >> 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= skc_pkg::UNITY_GAIN;
    end else begin
      gain_q <= gain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      skc_pkg::OP_LOAD: begin
        neg_q  <= sample_i[SB-1];
        zero_q <= (mag_in == '0);
        m_q    <= mag_in;
        pos_q  <= lead;
        y_q    <= skc_pkg::MANT_W'(mag_in) << lshift;
        frac_q <= '0;
      end
      skc_pkg::OP_LOG: begin
        if (sq_sh[31]) begin
          y_q    <= sq_sh >> 1;
          frac_q <= {frac_q[14:0], 1'b1};
        end else begin
          y_q    <= sq_sh;
          frac_q <= {frac_q[14:0], 1'b0};
        end
      end
      skc_pkg::OP_LEVEL: begin
        level_q <= zero_q ? skc_pkg::FLOOR_LEVEL : (skc_pkg::LEVEL_W'(0) - lvl_mag);
      end
      skc_pkg::OP_KNEE1: begin
        hi_q   <= level_x > (thr_x + 19'sd1536);
        mid_q  <= level_x > (thr_x - 19'sd1536);
        over_q <= skc_pkg::E_W'(diff);
        dd_q   <= 24'(dpos[11:0]) * 24'(dpos[11:0]);
        r_q    <= r_eff;
      end
      skc_pkg::OP_KNEE2: begin
        knum_q <= skc_pkg::NUM_W'(r_q - skc_pkg::RATIO_MIN) * skc_pkg::NUM_W'(dd_q);
      end
      skc_pkg::OP_DIV_INIT: begin
        rem_q <= '0;
        if (hi_q) begin
          quo_q <= skc_pkg::NUM_W'(over_q) << 8;
          div_q <= skc_pkg::DIV_W'(r_q);
        end else begin
          quo_q <= knum_q;
          div_q <= skc_pkg::DIV_W'(r_q) * skc_pkg::DIV_W'(6144);
        end
      end
      skc_pkg::OP_DIV: begin
        rem_q <= ge ? skc_pkg::DIV_W'(rem_s - {1'b0, div_q}) : skc_pkg::DIV_W'(rem_s);
        quo_q <= {quo_q[skc_pkg::NUM_W-2:0], ge};
      end
      skc_pkg::OP_GAIN_X: begin
        x_q    <= skc_pkg::X_W'(xp >> 16);
        mult_q <= skc_pkg::MULT_W'(1) << 30;
      end
      skc_pkg::OP_EXP: begin
        if (x_q[4'd15 - k]) begin
          mult_q <= skc_pkg::MULT_W'(ep >> 30);
        end
      end
      skc_pkg::OP_SHIFT: begin
        target_q <= (ip > 6'd31) ? '0 : skc_pkg::GAIN_W'(rsum >> sh);
      end
      skc_pkg::OP_OUT: begin
        sample_out_q <= neg_q ? (SB'(0) - mag_out) : mag_out;
        gain_out_q   <= gain_q;
      end
      default: begin
      end
    endcase
  end

  assign sample_out_o = sample_out_q;
  assign gain_now_o   = gain_out_q;

endmodule
